>>> rtl/sds_pkg.sv
// Shared types, codes and saturating arithmetic for the steepest-descent solver.
package sds_pkg;

  typedef enum logic [1:0] {
    MODE_MATRIX = 2'd0,
    MODE_RHS    = 2'd1,
    MODE_GUESS  = 2'd2,
    MODE_START  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_CONVERGED = 2'd0,
    STAT_LIMIT     = 2'd1,
    STAT_FLOOR     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_MAX_ITER = 2'd0,
    REG_TOL      = 2'd1,
    REG_FLOOR    = 2'd2,
    REG_SIZE     = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MV_RD, ST_MV_MUL, ST_MV_ACC, ST_ROW_WR, ST_LOOP,
    ST_D_RD, ST_D_SQ, ST_D_CR, ST_D_ACC, ST_CHECK, ST_DIV, ST_ALPHA,
    ST_U_RD, ST_U_M1, ST_U_M2, ST_U_M3, ST_U_M4, ST_U_ACC, ST_TEST,
    ST_O_RD, ST_O_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_MV_RD, OP_MUL_AV, OP_ACC, OP_ROW_WR,
    OP_SQ, OP_CROSS, OP_DOT_ACC, OP_DIV_START, OP_ALPHA,
    OP_UMUL_R, OP_UPD_X, OP_UPD_R, OP_SQ_NEW, OP_ACC_NEW
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load;
    logic   src_r;   // vector operand is the residual, else the solution
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic stop_floor;
    logic below_tol;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [63:0] sat_addu64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_adds64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

endpackage

>>> rtl/steepest_descent_spd_solver_top.sv
// Top level of the steepest-descent solver: configuration registers and wiring.
//
// Usage: items are offered on start with in_mode, in_row_index, in_column_index
// and in_data_value, and are taken at a clock edge where start is high and busy
// is low. Load items (matrix entry, rhs element, initial guess) are stored as
// they are taken and produce no result. A start item runs the whole solve:
// r = b - A x, then iterations that each wait on the bit-serial divider, paced
// by the single shared multiplier and the one-bit-per-cycle quotient loop.
// Afterwards the n solution elements leave on out_* with out_strobe high for
// one cycle each, out_last_element on the final one; busy falls after it.
// The receiver cannot hold results off.
// Configuration is written through cfg_we / cfg_index / cfg_wdata while idle.
// Reset (rst_n low, synchronous) restores the register defaults, returns the
// controller to idle and makes the solution store read as zero.
module steepest_descent_spd_solver_top import sds_pkg::*; #(
  parameter int DIMENSION     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [3:0]         in_row_index,
  input  logic [3:0]         in_column_index,
  input  logic signed [31:0] in_data_value,
  output logic               out_strobe,
  output logic [3:0]         out_element_index,
  output logic signed [31:0] out_element_value,
  output logic               out_last_element,
  output logic [1:0]         out_status,
  output logic [15:0]        out_iterations_used,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  localparam int IW = $clog2(DIMENSION);

  logic [15:0] iter_limit_r;
  logic [31:0] tol_r, floor_r;
  logic [4:0]  size_r;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [IW-1:0] idx_i, idx_j;
  logic [7:0]    idx_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_limit_r <= 16'd1000;
      tol_r        <= 32'd1;
      floor_r      <= 32'd1;
      size_r       <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_ITER: iter_limit_r <= cfg_wdata[15:0];
        REG_TOL:      tol_r        <= cfg_wdata;
        REG_FLOOR:    floor_r      <= cfg_wdata;
        REG_SIZE:     size_r       <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  sds_ctrl #(.DIMENSION(DIMENSION)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_mode     (in_mode),
    .iter_limit  (iter_limit_r),
    .size_in_use (size_r),
    .stat        (stat),
    .cmd         (cmd),
    .idx_i       (idx_i),
    .idx_j       (idx_j),
    .busy        (busy),
    .out_strobe  (out_strobe),
    .out_last    (out_last_element),
    .out_status  (out_status),
    .iters       (out_iterations_used)
  );

  sds_datapath #(.DIMENSION(DIMENSION), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .idx_i           (idx_i),
    .idx_j           (idx_j),
    .in_mode         (in_mode),
    .in_row_index    (in_row_index),
    .in_column_index (in_column_index),
    .in_data_value   (in_data_value),
    .tol             (tol_r),
    .floor_val       (floor_r),
    .stat            (stat),
    .sol_value       (out_element_value)
  );

  assign idx_ext           = 8'(idx_i);
  assign out_element_index = idx_ext[3:0];
endmodule

>>> rtl/sds_divider.sv
// Restoring bit-serial divider: (num << FRACTION_BITS) / den with overflow flag.
module sds_divider import sds_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [33:0] quot,
  output logic        ovf
);
  localparam int DW = 64 + FRACTION_BITS;
  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_r;
  logic [63:0]     rem_r, den_r;
  logic [33:0]     q_r;
  logic            ovf_r, busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [64:0]     sh, diff;
  logic            ge;

  assign sh   = {rem_r, dvd_r[DW-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num, {FRACTION_BITS{1'b0}}};
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= ge ? diff[63:0] : sh[63:0];
      q_r   <= {q_r[32:0], ge};
      ovf_r <= ovf_r | q_r[33];
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign ovf  = ovf_r;
endmodule

>>> rtl/sds_datapath.sv
// Datapath: stores, multiplier, accumulators, divider and vector updates.
module sds_datapath import sds_pkg::*; #(
  parameter int DIMENSION     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dp_cmd_t                     cmd,
  input  logic [$clog2(DIMENSION)-1:0] idx_i,
  input  logic [$clog2(DIMENSION)-1:0] idx_j,
  input  logic [1:0]                  in_mode,
  input  logic [3:0]                  in_row_index,
  input  logic [3:0]                  in_column_index,
  input  logic signed [31:0]          in_data_value,
  input  logic [31:0]                 tol,
  input  logic [31:0]                 floor_val,
  output dp_stat_t                    stat,
  output logic signed [31:0]          sol_value
);
  localparam int IW = $clog2(DIMENSION);
  localparam int CW = $clog2(DIMENSION * DIMENSION);

  logic signed [31:0] coef_mem [DIMENSION*DIMENSION];
  logic signed [31:0] rhs_mem  [DIMENSION];
  logic signed [31:0] sol_mem  [DIMENSION];
  logic signed [31:0] res_mem  [DIMENSION];
  logic signed [31:0] prod_mem [DIMENSION];
  logic [DIMENSION-1:0] sol_vld_r;

  logic signed [31:0] coef_q, rhs_q, sol_raw_q, res_q, prod_q, sol_q;
  logic               sol_vld_q;
  logic signed [63:0] mul_r, acc_r, rar_r;
  logic [63:0]        rr_r;
  logic signed [31:0] alpha_r, rnew_r;

  logic [IW-1:0] vaddr, ld_row, ld_col;
  logic [CW-1:0] caddr, ld_caddr;
  logic          row_ok, col_ok;
  logic          coef_we, rhs_we, sol_we, res_we, prod_we;
  logic [IW-1:0] sol_wa, res_wa;
  logic signed [31:0] sol_wd, res_wd, pval, xnew, rnew;
  logic signed [63:0] mulsh;
  logic [63:0]        mag;
  logic               div_busy, div_ovf;
  logic [33:0]        div_q;
  logic signed [31:0] alpha_nxt;

  assign vaddr    = (cmd.op == OP_MV_RD) ? idx_j : idx_i;
  assign caddr    = CW'(idx_i) * CW'(DIMENSION) + CW'(idx_j);
  assign ld_row   = IW'(in_row_index);
  assign ld_col   = IW'(in_column_index);
  assign ld_caddr = CW'(ld_row) * CW'(DIMENSION) + CW'(ld_col);
  assign row_ok   = {3'b0, in_row_index} < 7'(DIMENSION);
  assign col_ok   = {3'b0, in_column_index} < 7'(DIMENSION);

  assign mulsh = mul_r >>> FRACTION_BITS;
  assign pval  = sat32(acc_r);
  assign xnew  = sat32(64'(sol_q) + mulsh);
  assign rnew  = sat32(64'(res_q) - mulsh);

  assign coef_we = cmd.load && in_mode == MODE_MATRIX && row_ok && col_ok;
  assign rhs_we  = cmd.load && in_mode == MODE_RHS && row_ok;

  always_comb begin
    sol_we = 1'b0;
    sol_wa = idx_i;
    sol_wd = xnew;
    if (cmd.load && in_mode == MODE_GUESS && row_ok) begin
      sol_we = 1'b1;
      sol_wa = ld_row;
      sol_wd = in_data_value;
    end else if (cmd.op == OP_UPD_X) begin
      sol_we = 1'b1;
    end
  end

  always_comb begin
    res_we  = 1'b0;
    res_wa  = idx_i;
    res_wd  = rnew;
    prod_we = 1'b0;
    if (cmd.op == OP_ROW_WR) begin
      if (cmd.src_r) prod_we = 1'b1;
      else begin
        res_we = 1'b1;
        res_wd = sat32(64'(rhs_q) - 64'(pval));
      end
    end else if (cmd.op == OP_UPD_R) begin
      res_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) coef_mem[ld_caddr] <= in_data_value;
    coef_q <= coef_mem[caddr];
  end

  always_ff @(posedge clk) begin
    if (rhs_we) rhs_mem[ld_row] <= in_data_value;
    rhs_q <= rhs_mem[idx_i];
  end

  always_ff @(posedge clk) begin
    if (sol_we) sol_mem[sol_wa] <= sol_wd;
    sol_raw_q <= sol_mem[vaddr];
  end

  // solution store reads as zero until an entry is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sol_vld_r <= '0;
      sol_vld_q <= 1'b0;
    end else begin
      if (sol_we) sol_vld_r[sol_wa] <= 1'b1;
      sol_vld_q <= sol_vld_r[vaddr];
    end
  end
  assign sol_q = sol_vld_q ? sol_raw_q : 32'sd0;

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    res_q <= res_mem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (prod_we) prod_mem[idx_i] <= pval;
    prod_q <= prod_mem[idx_i];
  end

  assign mag = rar_r[63] ? 64'(-rar_r) : 64'(rar_r);

  sds_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIV_START),
    .num   (rr_r),
    .den   (mag),
    .busy  (div_busy),
    .quot  (div_q),
    .ovf   (div_ovf)
  );

  always_comb begin
    if (rar_r[63]) begin
      if (div_ovf || div_q > 34'h0_8000_0000) alpha_nxt = 32'sh8000_0000;
      else alpha_nxt = -$signed(div_q[31:0]);
    end else begin
      if (div_ovf || div_q > 34'h0_7FFF_FFFF) alpha_nxt = 32'sh7FFF_FFFF;
      else alpha_nxt = $signed(div_q[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CLEAR: begin
        acc_r <= '0;
        rr_r  <= '0;
        rar_r <= '0;
      end
      OP_MUL_AV: mul_r <= coef_q * (cmd.src_r ? res_q : sol_q);
      OP_ACC:    acc_r <= acc_r + mulsh;
      OP_ROW_WR: begin
        acc_r <= '0;
        rr_r  <= '0;
        rar_r <= '0;
      end
      OP_SQ: mul_r <= res_q * res_q;
      OP_CROSS: begin
        rr_r  <= sat_addu64(rr_r, mul_r);
        mul_r <= res_q * prod_q;
      end
      OP_DOT_ACC: rar_r <= sat_adds64(rar_r, mul_r);
      OP_ALPHA: begin
        alpha_r <= alpha_nxt;
        rr_r    <= '0;
      end
      OP_UMUL_R: mul_r <= alpha_r * res_q;
      OP_UPD_X:  mul_r <= alpha_r * prod_q;
      OP_UPD_R:  rnew_r <= rnew;
      OP_SQ_NEW: mul_r <= rnew_r * rnew_r;
      OP_ACC_NEW: rr_r <= sat_addu64(rr_r, mul_r);
      default: ;
    endcase
  end

  assign stat.div_busy   = div_busy;
  assign stat.stop_floor = (mag == 64'd0) || (mag < {32'd0, floor_val});
  assign stat.below_tol  = rr_r < {32'd0, tol};
  assign sol_value       = sol_q;
endmodule

>>> rtl/sds_ctrl.sv
// Controller: sequences the solve phases and drives the datapath.
module sds_ctrl import sds_pkg::*; #(
  parameter int DIMENSION = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [1:0]                   in_mode,
  input  logic [15:0]                  iter_limit,
  input  logic [4:0]                   size_in_use,
  input  dp_stat_t                     stat,
  output dp_cmd_t                      cmd,
  output logic [$clog2(DIMENSION)-1:0] idx_i,
  output logic [$clog2(DIMENSION)-1:0] idx_j,
  output logic                         busy,
  output logic                         out_strobe,
  output logic                         out_last,
  output logic [1:0]                   out_status,
  output logic [15:0]                  iters
);
  localparam int IW = $clog2(DIMENSION);

  state_t        state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [15:0]   iters_r, iters_nxt;
  status_t       status_r, status_nxt;
  logic          src_r_r, src_r_nxt;
  logic [6:0]    n7;
  logic [IW-1:0] nm1;
  logic          accept, i_last;

  always_comb begin
    if (size_in_use == 5'd0) n7 = 7'd1;
    else if ({2'b0, size_in_use} > 7'(DIMENSION)) n7 = 7'(DIMENSION);
    else n7 = {2'b0, size_in_use};
  end
  assign nm1    = IW'(n7 - 7'd1);
  assign accept = start && state_r == ST_IDLE;
  assign i_last = i_r == nm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      i_r      <= '0;
      j_r      <= '0;
      iters_r  <= '0;
      status_r <= STAT_LIMIT;
      src_r_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      iters_r  <= iters_nxt;
      status_r <= status_nxt;
      src_r_r  <= src_r_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    iters_nxt  = iters_r;
    status_nxt = status_r;
    src_r_nxt  = src_r_r;
    cmd.op     = OP_NONE;
    cmd.load   = 1'b0;
    cmd.src_r  = src_r_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_START) begin
            cmd.op    = OP_CLEAR;
            i_nxt     = '0;
            j_nxt     = '0;
            iters_nxt = '0;
            src_r_nxt = 1'b0;
            state_nxt = ST_MV_RD;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_MV_RD: begin
        cmd.op    = OP_MV_RD;
        state_nxt = ST_MV_MUL;
      end
      ST_MV_MUL: begin
        cmd.op    = OP_MUL_AV;
        state_nxt = ST_MV_ACC;
      end
      ST_MV_ACC: begin
        cmd.op = OP_ACC;
        if (j_r == nm1) begin
          j_nxt     = '0;
          state_nxt = ST_ROW_WR;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_MV_RD;
        end
      end
      ST_ROW_WR: begin
        cmd.op = OP_ROW_WR;
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = src_r_r ? ST_D_RD : ST_LOOP;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_MV_RD;
        end
      end
      ST_LOOP: begin
        i_nxt = '0;
        j_nxt = '0;
        if (iters_r < iter_limit) begin
          src_r_nxt = 1'b1;
          state_nxt = ST_MV_RD;
        end else begin
          status_nxt = STAT_LIMIT;
          state_nxt  = ST_O_RD;
        end
      end
      ST_D_RD: state_nxt = ST_D_SQ;
      ST_D_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = ST_D_CR;
      end
      ST_D_CR: begin
        cmd.op    = OP_CROSS;
        state_nxt = ST_D_ACC;
      end
      ST_D_ACC: begin
        cmd.op = OP_DOT_ACC;
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = ST_CHECK;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_D_RD;
        end
      end
      ST_CHECK: begin
        if (stat.stop_floor) begin
          status_nxt = STAT_FLOOR;
          state_nxt  = ST_O_RD;
        end else begin
          cmd.op    = OP_DIV_START;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: if (!stat.div_busy) state_nxt = ST_ALPHA;
      ST_ALPHA: begin
        cmd.op    = OP_ALPHA;
        state_nxt = ST_U_RD;
      end
      ST_U_RD: state_nxt = ST_U_M1;
      ST_U_M1: begin
        cmd.op    = OP_UMUL_R;
        state_nxt = ST_U_M2;
      end
      ST_U_M2: begin
        cmd.op    = OP_UPD_X;
        state_nxt = ST_U_M3;
      end
      ST_U_M3: begin
        cmd.op    = OP_UPD_R;
        state_nxt = ST_U_M4;
      end
      ST_U_M4: begin
        cmd.op    = OP_SQ_NEW;
        state_nxt = ST_U_ACC;
      end
      ST_U_ACC: begin
        cmd.op = OP_ACC_NEW;
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = ST_TEST;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_U_RD;
        end
      end
      ST_TEST: begin
        iters_nxt = iters_r + 1'b1;
        if (stat.below_tol) begin
          status_nxt = STAT_CONVERGED;
          state_nxt  = ST_O_RD;
        end else begin
          state_nxt = ST_LOOP;
        end
      end
      ST_O_RD: state_nxt = ST_O_EMIT;
      ST_O_EMIT: begin
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_O_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign idx_i      = i_r;
  assign idx_j      = j_r;
  assign busy       = state_r != ST_IDLE;
  assign out_strobe = state_r == ST_O_EMIT;
  assign out_last   = out_strobe && i_last;
  assign out_status = status_r;
  assign iters      = iters_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == MODE_START |=> busy)
    else $error("start item did not begin a solve");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !busy)
    else $error("block still busy after last element");

  a_iter_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> iters_r <= iter_limit)
    else $error("iteration count above limit");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_DIV_START |-> !stat.div_busy)
    else $error("divider restarted while busy");
endmodule

>>> verif/steepest_descent_spd_solver_top_tb.sv
// Self-checking testbench for the steepest-descent solver: loads, solves and solution checks.
`timescale 1ns / 1ps

module steepest_descent_spd_solver_top_tb;
  import sds_pkg::*;

  localparam int N_MAX = 16;
  localparam int FRAC = 16;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    int unsigned idx;
    int          value;
    bit          last;
    int unsigned status;
    int unsigned iters;
  } sol_elem_t;

  class solve_scoreboard;
    int coef [N_MAX][N_MAX];
    int rhs [N_MAX];
    int sol [N_MAX];
    int res [N_MAX];
    int prod [N_MAX];
    int unsigned iter_limit = 1000;
    int unsigned tol_sq = 1;
    int unsigned den_floor = 1;
    int unsigned size_reg = 16;
    sol_elem_t solution_q[$];
    int errors;
    int solves;
    int elems_seen;
    int status_seen [3];

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_MAX_ITER: iter_limit = v[15:0];
        REG_TOL:      tol_sq = v;
        REG_FLOOR:    den_floor = v;
        REG_SIZE:     size_reg = v[4:0];
        default: ;
      endcase
    endfunction

    function int clamp32(longint x);
      if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'sh8000_0000;
      return int'(x);
    endfunction

    // prod = A * (res or sol), floor shift per product, saturate per row
    function void mat_vec(bit use_res, int n);
      longint acc;
      longint p;
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++) begin
          p = longint'(coef[i][j]) * longint'(use_res ? res[j] : sol[j]);
          acc += p >>> FRAC;
        end
        prod[i] = clamp32(acc);
      end
    endfunction

    function longint unsigned res_norm_sq(int n);
      longint unsigned acc;
      longint unsigned sq;
      acc = 0;
      for (int i = 0; i < n; i++) begin
        sq = longint'(res[i]) * longint'(res[i]);
        acc = (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + sq;
      end
      return acc;
    endfunction

    function longint res_dot_prod(int n);
      longint acc;
      longint b;
      acc = 0;
      for (int i = 0; i < n; i++) begin
        b = longint'(res[i]) * longint'(prod[i]);
        if (b > 0 && acc > 64'sh7FFF_FFFF_FFFF_FFFF - b) acc = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (b < 0 && acc < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - b)
          acc = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
        else acc = acc + b;
      end
      return acc;
    endfunction

    // (num << FRAC) / den, truncated, capped at 2^33
    function longint unsigned step_quotient(longint unsigned num, longint unsigned den);
      longint unsigned cap;
      longint unsigned q;
      longint unsigned rem;
      cap = 64'd1 << 33;
      q = num / den;
      rem = num % den;
      if (q > cap) return cap;
      for (int k = 0; k < FRAC; k++) begin
        if (q > cap) return cap;
        q = q << 1;
        if (rem >= den - rem) begin
          rem = rem - (den - rem);
          q++;
        end else begin
          rem = rem << 1;
        end
      end
      return q;
    endfunction

    function void note_item(mode_t m, int row, int col, int v);
      int n;
      int unsigned iters;
      int unsigned stat;
      longint unsigned rr;
      longint unsigned mag;
      longint unsigned q;
      longint rar;
      longint alpha;
      sol_elem_t e;
      case (m)
        MODE_MATRIX: coef[row][col] = v;
        MODE_RHS:    rhs[row] = v;
        MODE_GUESS:  sol[row] = v;
        default: begin
          n = size_reg;
          if (n < 1) n = 1;
          if (n > N_MAX) n = N_MAX;
          iters = 0;
          stat = STAT_LIMIT;
          mat_vec(1'b0, n);
          for (int i = 0; i < n; i++) res[i] = clamp32(longint'(rhs[i]) - longint'(prod[i]));
          while (iters < iter_limit) begin
            mat_vec(1'b1, n);
            rr = res_norm_sq(n);
            rar = res_dot_prod(n);
            mag = (rar < 0) ? longint'(-(rar + 1)) + 64'd1 : rar;
            if (mag == 0 || mag < den_floor) begin
              stat = STAT_FLOOR;
              break;
            end
            q = step_quotient(rr, mag);
            if (rar < 0) alpha = (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
            else alpha = (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
            for (int i = 0; i < n; i++)
              sol[i] = clamp32(longint'(sol[i]) + ((alpha * longint'(res[i])) >>> FRAC));
            for (int i = 0; i < n; i++)
              res[i] = clamp32(longint'(res[i]) - ((alpha * longint'(prod[i])) >>> FRAC));
            iters++;
            if (res_norm_sq(n) < longint'(tol_sq)) begin
              stat = STAT_CONVERGED;
              break;
            end
          end
          solves++;
          status_seen[stat]++;
          for (int i = 0; i < n; i++) begin
            e.idx = i;
            e.value = sol[i];
            e.last = (i == n - 1);
            e.status = stat;
            e.iters = iters & 16'hFFFF;
            solution_q.push_back(e);
          end
        end
      endcase
    endfunction

    function void check(sol_elem_t got);
      sol_elem_t exp_e;
      if (solution_q.size() == 0) begin
        $display("%0t: unexpected element: idx %0d value %0d", $time, got.idx, got.value);
        errors++;
        return;
      end
      exp_e = solution_q.pop_front();
      elems_seen++;
      if (got.idx != exp_e.idx) begin
        $display("%0t: element_index expected %0d actual %0d", $time, exp_e.idx, got.idx);
        errors++;
      end
      if (got.value != exp_e.value) begin
        $display("%0t: element_value[%0d] expected %0d actual %0d", $time, exp_e.idx,
                 exp_e.value, got.value);
        errors++;
      end
      if (got.last != exp_e.last) begin
        $display("%0t: last_element[%0d] expected %0d actual %0d", $time, exp_e.idx,
                 exp_e.last, got.last);
        errors++;
      end
      if (got.status != exp_e.status) begin
        $display("%0t: status[%0d] expected %0d actual %0d", $time, exp_e.idx,
                 exp_e.status, got.status);
        errors++;
      end
      if (got.iters != exp_e.iters) begin
        $display("%0t: iterations_used[%0d] expected %0d actual %0d", $time, exp_e.idx,
                 exp_e.iters, got.iters);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_mode;
  logic [3:0]         in_row_index;
  logic [3:0]         in_column_index;
  logic signed [31:0] in_data_value;
  logic               out_strobe;
  logic [3:0]         out_element_index;
  logic signed [31:0] out_element_value;
  logic               out_last_element;
  logic [1:0]         out_status;
  logic [15:0]        out_iterations_used;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_wdata;

  solve_scoreboard sb;
  longint cycles;
  int items_sent;

  steepest_descent_spd_solver_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_row_index        (in_row_index),
    .in_column_index     (in_column_index),
    .in_data_value       (in_data_value),
    .out_strobe          (out_strobe),
    .out_element_index   (out_element_index),
    .out_element_value   (out_element_value),
    .out_last_element    (out_last_element),
    .out_status          (out_status),
    .out_iterations_used (out_iterations_used),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d elements outstanding", cycles,
               sb.solution_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    sol_elem_t got;
    if (rst_n && out_strobe) begin
      got.idx = out_element_index;
      got.value = out_element_value;
      got.last = out_last_element;
      got.status = out_status;
      got.iters = out_iterations_used;
      sb.check(got);
    end
  end

  // Called right after a rising edge; returns right after the edge that takes the item.
  task automatic send_item(mode_t m, int row, int col, int v, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_row_index <= row[3:0];
    in_column_index <= col[3:0];
    in_data_value <= v;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_item(m, row, col, v);
    items_sent++;
  endtask

  task automatic send(mode_t m, int row, int col, int v);
    send_item(m, row, col, v, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
  endtask

  // Wait for all expected elements, then for the block to drop busy.
  task automatic drain();
    start <= 1'b0;
    while (sb.solution_q.size() > 0) @(posedge clk);
    @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Symmetric, diagonally dominant n x n system with random rhs.
  task automatic load_system(int n);
    int a;
    for (int i = 0; i < n; i++) begin
      send(MODE_MATRIX, i, i, 32'h0001_0000 * n / 2 + $urandom_range(32'h0001_0000, 32'h0003_0000));
      for (int j = i + 1; j < n; j++) begin
        a = int'($urandom_range(0, 32768)) - 16384;
        send(MODE_MATRIX, i, j, a);
        send(MODE_MATRIX, j, i, a);
      end
      send(MODE_RHS, i, 0, int'($urandom_range(0, 32'h000A_0000)) - 32'h0005_0000);
    end
  endtask

  initial begin
    int n;
    int phase;
    int loaded;
    sb = new();
    cycles = 0;
    items_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_MATRIX;
    in_row_index = '0;
    in_column_index = '0;
    in_data_value = '0;
    cfg_we = 1'b0;
    cfg_index = REG_MAX_ITER;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero iteration limit at full size, the cleared solution comes back
    write_reg(REG_MAX_ITER, 0);
    send(MODE_START, 0, 0, 0);
    drain();
    // zero residual with zero floor, size 0 acting as 1
    write_reg(REG_FLOOR, 0);
    write_reg(REG_SIZE, 0);
    write_reg(REG_MAX_ITER, 16'hFFFF);
    send(MODE_MATRIX, 0, 0, 32'h0008_0000);
    send(MODE_RHS, 0, 15, 0);
    send(MODE_GUESS, 0, 15, 0);
    send(MODE_START, 15, 15, 32'hFFFF_FFFF);
    drain();
    // field extremes on a 1x1 system, loose tolerance so it converges quickly
    write_reg(REG_TOL, 32'hFFFF_FFFF);
    write_reg(REG_FLOOR, 32'hFFFF_FFFF);
    send(MODE_MATRIX, 0, 0, 32'h7FFF_FFFF);
    send(MODE_RHS, 0, 0, 32'h8000_0000);
    send(MODE_GUESS, 0, 0, 32'h7FFF_FFFF);
    send(MODE_START, 0, 0, 0);
    drain();
    // size above the dimension acts as the dimension; no iterations at full size
    write_reg(REG_FLOOR, 1);
    write_reg(REG_TOL, 1);
    write_reg(REG_MAX_ITER, 0);
    write_reg(REG_SIZE, 31);
    send(MODE_GUESS, 15, 0, 32'h8000_0000);
    send(MODE_START, 0, 0, 0);
    // repeated start keeps the last solution
    send(MODE_START, 0, 0, 0);
    drain();
    write_reg(REG_SIZE, 2);
    write_reg(REG_MAX_ITER, 1);
    load_system(2);
    send(MODE_START, 0, 0, 0);
    drain();
    loaded = 2;

    // random phases: mostly well-formed small systems, some noise loads
    phase = 0;
    while (items_sent < 150) begin
      phase++;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
      write_reg(REG_SIZE, n);
      write_reg(REG_MAX_ITER, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10));
      write_reg(REG_TOL, ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 4096));
      write_reg(REG_FLOOR, ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 16));
      // a solve only reads entries that have been loaded at some point
      if (n > loaded || $urandom_range(0, 4) != 0) begin
        load_system(n);
        if (n > loaded) loaded = n;
      end
      repeat ($urandom_range(0, 4))
        send(mode_t'($urandom_range(0, 2)), $urandom_range(0, 15), $urandom_range(0, 15),
             $urandom());
      if ($urandom_range(0, 1) == 0)
        for (int i = 0; i < n; i++) send(MODE_GUESS, i, 0, int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000);
      send(MODE_START, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
      if ($urandom_range(0, 2) == 0) send(MODE_START, 0, 0, 0);
      // the sender holds off until every element of this phase has arrived
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d items, %0d solves (%0d converged, %0d at limit, %0d below floor)",
             items_sent, sb.solves, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
    $display("%0d solution elements checked over %0d random phases, %0d mismatches",
             sb.elems_seen, phase, sb.errors);
    if (sb.errors == 0 && sb.solution_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
